>>> design/tcw_pkg.sv
package tcw_pkg;

  localparam int unsigned ReadIdxW = 11;
  localparam int unsigned RowW     = 5;
  localparam int unsigned ColW     = 7;

  localparam logic [7:0] BlankChar   = 8'h20;
  localparam logic [7:0] ResetAttr   = 8'h0f;
  localparam logic [7:0] CharTab     = 8'd9;
  localparam logic [7:0] CharNewline = 8'd10;
  localparam logic [7:0] CharReturn  = 8'd13;
  localparam int unsigned TabStop    = 8;

  localparam logic [1:0] ModePut   = 2'd0;
  localparam logic [1:0] ModeClear = 2'd1;

  typedef logic [RowW-1:0]     cursor_row_t;
  typedef logic [ColW-1:0]     cursor_col_t;
  typedef logic [ReadIdxW-1:0] read_index_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  char_code;
    read_index_t read_index;
  } item_t;

  typedef struct packed {
    cursor_row_t cursor_row;
    cursor_col_t cursor_col;
    logic [7:0]  cell_char;
    logic [7:0]  cell_attr;
  } result_t;

  typedef enum logic [2:0] {
    OP_CHAR,
    OP_NEWLINE,
    OP_RETURN,
    OP_TAB,
    OP_CLEAR,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [7:0]  ch;
    read_index_t read_index;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_TAB,
    ST_SCROLL,
    ST_CLEAR,
    ST_READ,
    ST_RES
  } back_state_e;

endpackage

>>> design/tcw_fifo.sv
module tcw_fifo #(
  parameter type         T     = logic,
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  input  logic pop_i,
  output T     data_o,
  output logic empty_o
);

  localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  T                store_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            push_ok, pop_ok;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = store_q[rd_q];
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_ok) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_ok) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + CNTW'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      store_q[wr_q] <= data_i;
    end
  end

endmodule

>>> design/tcw_front.sv
module tcw_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tcw_pkg::item_t item_i,
  output logic          full_o,
  input  logic          cmd_pop_i,
  output tcw_pkg::cmd_t cmd_o,
  output logic          cmd_empty_o
);

  tcw_pkg::cmd_t cmd;

  always_comb begin
    cmd.ch         = item_i.char_code;
    cmd.read_index = item_i.read_index;
    if (item_i.mode == tcw_pkg::ModePut) begin
      case (item_i.char_code)
        tcw_pkg::CharNewline: cmd.op = tcw_pkg::OP_NEWLINE;
        tcw_pkg::CharReturn:  cmd.op = tcw_pkg::OP_RETURN;
        tcw_pkg::CharTab:     cmd.op = tcw_pkg::OP_TAB;
        default:              cmd.op = tcw_pkg::OP_CHAR;
      endcase
    end else if (item_i.mode == tcw_pkg::ModeClear) begin
      cmd.op = tcw_pkg::OP_CLEAR;
    end else begin
      cmd.op = tcw_pkg::OP_READ;
    end
  end

  tcw_fifo #(
    .T     (tcw_pkg::cmd_t),
    .DEPTH (2)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push_i),
    .data_i  (cmd),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty_o)
  );

endmodule

>>> design/tcw_back.sv
module tcw_back #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       attr_i,
  input  tcw_pkg::cmd_t    cmd_i,
  input  logic             cmd_empty_i,
  output logic             cmd_pop_o,
  output tcw_pkg::result_t res_o,
  output logic             res_push_o,
  input  logic             res_full_i,
  output logic             init_busy_o
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned IW    = $clog2(CELLS + 1);
  localparam int unsigned RW    = $clog2(ROWS + 1);
  localparam int unsigned CW    = $clog2(COLUMNS);
  localparam int unsigned SW    = ((IW > tcw_pkg::ReadIdxW) ? IW : tcw_pkg::ReadIdxW) + 1;

  tcw_pkg::back_state_e state_q, state_d, ret_q, ret_d;
  tcw_pkg::cmd_t        cmd_q, cmd_d;
  logic [AW-1:0]        cnt_q, cnt_d, top_q, top_d;
  logic [3:0]           tab_q, tab_d;
  logic [RW-1:0]        row_q, row_d;
  logic [CW-1:0]        col_q, col_d;
  logic [IW-1:0]        idx_q, idx_d;

  logic [15:0]          mem [CELLS];
  logic [15:0]          rdata_q;
  logic                 rd_ok_q;

  logic                 we, re;
  logic [AW-1:0]        waddr, raddr, cur_addr, top_next;
  logic [15:0]          wdata;
  logic [SW-1:0]        cur_sum, rd_sum, top_sum;
  logic                 rd_in;
  logic [RW-1:0]        adv_row;
  logic [CW-1:0]        adv_col;
  logic [IW-1:0]        adv_idx;
  logic                 is_put;

  // logical index to physical cell through the rotating top-row offset
  assign cur_sum  = SW'(idx_q) + SW'(top_q);
  assign cur_addr = (cur_sum >= SW'(CELLS)) ? AW'(cur_sum - SW'(CELLS)) : AW'(cur_sum);
  assign rd_sum   = SW'(cmd_q.read_index) + SW'(top_q);
  assign raddr    = (rd_sum >= SW'(CELLS)) ? AW'(rd_sum - SW'(CELLS)) : AW'(rd_sum);
  assign rd_in    = SW'(cmd_q.read_index) < SW'(CELLS);
  assign top_sum  = SW'(top_q) + SW'(COLUMNS);
  assign top_next = (top_sum >= SW'(CELLS)) ? AW'(top_sum - SW'(CELLS)) : AW'(top_sum);

  always_comb begin
    adv_idx = idx_q + IW'(1);
    if (col_q == CW'(COLUMNS - 1)) begin
      adv_col = '0;
      adv_row = row_q + RW'(1);
    end else begin
      adv_col = col_q + CW'(1);
      adv_row = row_q;
    end
  end

  assign is_put = (cmd_i.op != tcw_pkg::OP_CLEAR) && (cmd_i.op != tcw_pkg::OP_READ);

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    cmd_d      = cmd_q;
    cnt_d      = cnt_q;
    top_d      = top_q;
    tab_d      = tab_q;
    row_d      = row_q;
    col_d      = col_q;
    idx_d      = idx_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    we         = 1'b0;
    re         = 1'b0;
    waddr      = cur_addr;
    wdata      = {attr_i, tcw_pkg::BlankChar};
    case (state_q)
      tcw_pkg::ST_INIT: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = {tcw_pkg::ResetAttr, tcw_pkg::BlankChar};
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == AW'(CELLS - 1)) begin
          cnt_d   = '0;
          state_d = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          ret_d     = tcw_pkg::ST_EXEC;
          cnt_d     = '0;
          if (is_put && (row_q == RW'(ROWS))) begin
            state_d = tcw_pkg::ST_SCROLL;
          end else begin
            state_d = tcw_pkg::ST_EXEC;
          end
        end
      end
      tcw_pkg::ST_EXEC: begin
        state_d = tcw_pkg::ST_READ;
        case (cmd_q.op)
          tcw_pkg::OP_CHAR: begin
            we    = 1'b1;
            wdata = {attr_i, cmd_q.ch};
            row_d = adv_row;
            col_d = adv_col;
            idx_d = adv_idx;
          end
          tcw_pkg::OP_NEWLINE: begin
            row_d = row_q + RW'(1);
            col_d = '0;
            idx_d = idx_q - IW'(col_q) + IW'(COLUMNS);
          end
          tcw_pkg::OP_RETURN: begin
            col_d = '0;
            idx_d = idx_q - IW'(col_q);
          end
          tcw_pkg::OP_TAB: begin
            tab_d   = 4'(tcw_pkg::TabStop) - {1'b0, col_q[2:0]};
            state_d = tcw_pkg::ST_TAB;
          end
          tcw_pkg::OP_CLEAR: begin
            cnt_d   = '0;
            state_d = tcw_pkg::ST_CLEAR;
          end
          default: begin
            state_d = tcw_pkg::ST_READ;
          end
        endcase
      end
      tcw_pkg::ST_TAB: begin
        we    = 1'b1;
        row_d = adv_row;
        col_d = adv_col;
        idx_d = adv_idx;
        tab_d = tab_q - 4'd1;
        if (adv_idx == IW'(CELLS)) begin
          cnt_d   = '0;
          ret_d   = (tab_q == 4'd1) ? tcw_pkg::ST_READ : tcw_pkg::ST_TAB;
          state_d = tcw_pkg::ST_SCROLL;
        end else begin
          state_d = (tab_q == 4'd1) ? tcw_pkg::ST_READ : tcw_pkg::ST_TAB;
        end
      end
      tcw_pkg::ST_SCROLL: begin
        // old top row becomes the blank bottom row
        we    = 1'b1;
        waddr = top_q + cnt_q;
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == AW'(COLUMNS - 1)) begin
          cnt_d   = '0;
          top_d   = top_next;
          idx_d   = IW'(CELLS - COLUMNS);
          row_d   = RW'(ROWS - 1);
          col_d   = '0;
          state_d = ret_q;
        end
      end
      tcw_pkg::ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q;
        cnt_d = cnt_q + AW'(1);
        if (cnt_q == AW'(CELLS - 1)) begin
          cnt_d   = '0;
          idx_d   = '0;
          row_d   = '0;
          col_d   = '0;
          state_d = tcw_pkg::ST_READ;
        end
      end
      tcw_pkg::ST_READ: begin
        re      = 1'b1;
        state_d = tcw_pkg::ST_RES;
      end
      tcw_pkg::ST_RES: begin
        if (!res_full_i) begin
          res_push_o = 1'b1;
          state_d    = tcw_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcw_pkg::ST_INIT;
      ret_q   <= tcw_pkg::ST_IDLE;
      cnt_q   <= '0;
      top_q   <= '0;
      tab_q   <= '0;
      row_q   <= '0;
      col_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
      top_q   <= top_d;
      tab_q   <= tab_d;
      row_q   <= row_d;
      col_q   <= col_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
      rd_ok_q <= rd_in;
    end
  end

  assign res_o.cursor_row = tcw_pkg::cursor_row_t'(row_q);
  assign res_o.cursor_col = tcw_pkg::cursor_col_t'(col_q);
  assign res_o.cell_char  = rd_ok_q ? rdata_q[7:0] : 8'h00;
  assign res_o.cell_attr  = rd_ok_q ? rdata_q[15:8] : 8'h00;
  assign init_busy_o      = (state_q == tcw_pkg::ST_INIT);

endmodule

>>> design/text_console_writer.sv
// Text console over a COLUMNS x ROWS cell store (character and attribute per
// cell), fed by a queue-style push/full port and drained by an empty/pop
// result queue, one result per beat. Scrolling rotates a top-row offset and
// blanks only the new bottom row. The cell store has a single write and a
// single read port, and one sequencer walks it a cell per cycle: a printable
// character, newline, return or read passes the execute, read and result
// states, a tab adds a blank write per space, a scroll a sweep over the COLUMNS
// cells of the recycled row, and a clear a sweep over all COLUMNS*ROWS cells.
// After reset the store is blanked cell by cell, during which full stays high.
// The attribute register may be written at any time through the cfg port and
// is taken by the next characters written.
module text_console_writer #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  input  tcw_pkg::item_t   item_i,
  output logic             full,
  output logic             empty,
  input  logic             pop,
  output tcw_pkg::result_t result_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [7:0]       cfg_data_i
);

  logic [7:0]       attr_q;
  logic             front_full, init_busy;
  tcw_pkg::cmd_t    cmd;
  logic             cmd_empty, cmd_pop;
  tcw_pkg::result_t res;
  logic             res_push, res_full;

  assign cfg_ready_o = 1'b1;
  assign full        = front_full || init_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= tcw_pkg::ResetAttr;
    end else if (cfg_valid_i && cfg_ready_o) begin
      attr_q <= cfg_data_i;
    end
  end

  tcw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push && !init_busy),
    .item_i      (item_i),
    .full_o      (front_full),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .attr_i      (attr_q),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res),
    .res_push_o  (res_push),
    .res_full_i  (res_full),
    .init_busy_o (init_busy)
  );

  tcw_fifo #(
    .T     (tcw_pkg::result_t),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty)
  );

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (32'(result_o.cursor_row) <= ROWS))
    else $error("cursor row past pending position");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (32'(result_o.cursor_col) < COLUMNS))
    else $error("cursor column out of range");

  a_pending_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ROWS < 32) && !empty && (result_o.cursor_row == tcw_pkg::cursor_row_t'(ROWS))
      |-> (result_o.cursor_col == '0))
    else $error("pending scroll with non-zero column");

  a_init_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy |-> empty && cmd_empty)
    else $error("work seen during reset sweep");

endmodule
